// ----- hw/rtl/scta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_pkg
// Word types, key codes and US-layout lookup tables for the set 1 translator.
// ----------------------------------------------------------------------------
package scta_pkg;

    // One controller poll.
    typedef struct packed {
        logic       buffer_full;
        logic       from_aux;
        logic [7:0] scan_code;
    } poll_word_t;

    // One translated character.
    typedef struct packed {
        logic [6:0] ascii_char;
    } char_word_t;

    // Decode result handed back to the pipeline control.
    typedef struct packed {
        logic       emit;
        logic [6:0] ascii_char;
        logic       shift_held;
        logic       caps_lock_on;
    } scta_dec_t;

    localparam int unsigned BREAK_BIT = 7;

    // Key codes with the release bit stripped.
    localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT   = 7'h36;
    localparam logic [6:0] KEY_CAPSLOCK = 7'h3A;

    localparam logic [6:0] CHAR_NONE    = 7'h00;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

    // Unshifted character for make codes below caps lock; zero where ignored.
    function automatic logic [6:0] plain_char(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'h02: ch = 7'h31;  // 1
            6'h03: ch = 7'h32;
            6'h04: ch = 7'h33;
            6'h05: ch = 7'h34;
            6'h06: ch = 7'h35;
            6'h07: ch = 7'h36;
            6'h08: ch = 7'h37;
            6'h09: ch = 7'h38;
            6'h0A: ch = 7'h39;
            6'h0B: ch = 7'h30;  // 0
            6'h0C: ch = 7'h2D;  // -
            6'h0D: ch = 7'h3D;  // =
            6'h0E: ch = 7'h08;  // backspace
            6'h0F: ch = 7'h09;  // tab
            6'h10: ch = 7'h71;  // q
            6'h11: ch = 7'h77;
            6'h12: ch = 7'h65;
            6'h13: ch = 7'h72;
            6'h14: ch = 7'h74;
            6'h15: ch = 7'h79;
            6'h16: ch = 7'h75;
            6'h17: ch = 7'h69;
            6'h18: ch = 7'h6F;
            6'h19: ch = 7'h70;  // p
            6'h1A: ch = 7'h5B;  // [
            6'h1B: ch = 7'h5D;  // ]
            6'h1C: ch = 7'h0A;  // enter
            6'h1E: ch = 7'h61;  // a
            6'h1F: ch = 7'h73;
            6'h20: ch = 7'h64;
            6'h21: ch = 7'h66;
            6'h22: ch = 7'h67;
            6'h23: ch = 7'h68;
            6'h24: ch = 7'h6A;
            6'h25: ch = 7'h6B;
            6'h26: ch = 7'h6C;  // l
            6'h27: ch = 7'h3B;  // ;
            6'h28: ch = 7'h27;  // '
            6'h29: ch = 7'h60;  // `
            6'h2B: ch = 7'h5C;  // backslash
            6'h2C: ch = 7'h7A;  // z
            6'h2D: ch = 7'h78;
            6'h2E: ch = 7'h63;
            6'h2F: ch = 7'h76;
            6'h30: ch = 7'h62;
            6'h31: ch = 7'h6E;
            6'h32: ch = 7'h6D;  // m
            6'h33: ch = 7'h2C;  // ,
            6'h34: ch = 7'h2E;  // .
            6'h35: ch = 7'h2F;  // /
            6'h39: ch = 7'h20;  // space
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    // Shifted character for the same codes.
    function automatic logic [6:0] shifted_char(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'h02: ch = 7'h21;  // !
            6'h03: ch = 7'h40;  // @
            6'h04: ch = 7'h23;  // #
            6'h05: ch = 7'h24;  // $
            6'h06: ch = 7'h25;  // %
            6'h07: ch = 7'h5E;  // ^
            6'h08: ch = 7'h26;  // &
            6'h09: ch = 7'h2A;  // *
            6'h0A: ch = 7'h28;  // (
            6'h0B: ch = 7'h29;  // )
            6'h0C: ch = 7'h5F;  // _
            6'h0D: ch = 7'h2B;  // +
            6'h0E: ch = 7'h08;
            6'h0F: ch = 7'h09;
            6'h10: ch = 7'h51;  // Q
            6'h11: ch = 7'h57;
            6'h12: ch = 7'h45;
            6'h13: ch = 7'h52;
            6'h14: ch = 7'h54;
            6'h15: ch = 7'h59;
            6'h16: ch = 7'h55;
            6'h17: ch = 7'h49;
            6'h18: ch = 7'h4F;
            6'h19: ch = 7'h50;  // P
            6'h1A: ch = 7'h7B;  // {
            6'h1B: ch = 7'h7D;  // }
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h41;  // A
            6'h1F: ch = 7'h53;
            6'h20: ch = 7'h44;
            6'h21: ch = 7'h46;
            6'h22: ch = 7'h47;
            6'h23: ch = 7'h48;
            6'h24: ch = 7'h4A;
            6'h25: ch = 7'h4B;
            6'h26: ch = 7'h4C;  // L
            6'h27: ch = 7'h3A;  // :
            6'h28: ch = 7'h22;  // "
            6'h29: ch = 7'h7E;  // ~
            6'h2B: ch = 7'h7C;  // |
            6'h2C: ch = 7'h5A;  // Z
            6'h2D: ch = 7'h58;
            6'h2E: ch = 7'h43;
            6'h2F: ch = 7'h56;
            6'h30: ch = 7'h42;
            6'h31: ch = 7'h4E;
            6'h32: ch = 7'h4D;  // M
            6'h33: ch = 7'h3C;  // <
            6'h34: ch = 7'h3E;  // >
            6'h35: ch = 7'h3F;  // ?
            6'h39: ch = 7'h20;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/scta_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_stream_if
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface scta_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/scan_code_set1_to_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii
// PS/2 scan code set 1 to US-layout ASCII translator.
//
// Each poll word (buffer_full, from_aux, scan_code) goes into an input
// register, is decoded by a small table lookup in the next cycle and, if it
// names a printable or control key, lands in the result register as one
// 7-bit ASCII character. Empty polls, mouse bytes, releases, modifier makes,
// unmapped keys and codes from caps lock upward produce no character. Left
// and right shift set the shift flag on make and clear it on release; caps
// lock toggles on each make. Letters come out upper case when shift XOR caps
// lock, other keys take their shifted form while shift is held. Reset clears
// both flags. Throughput is one poll word per cycle unless a character
// waits on a stalled result channel. A character passes through the input
// register, then the result register, which loads only when it is empty or
// being drained. A stalled result channel holds one character plus one poll
// word in the input register before poll.ready drops.
// ----------------------------------------------------------------------------
module scan_code_set1_to_ascii
    import scta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    scta_stream_if.sink          poll,
    scta_stream_if.source        result
);

    // Input stage.
    logic       poll_valid_reg;
    poll_word_t poll_word_reg;

    // Modifier flags.
    logic       shift_reg;
    logic       shift_next;
    logic       caps_reg;
    logic       caps_next;

    // Result stage.
    logic       result_valid_reg;
    logic       result_valid_next;
    logic [6:0] result_char_reg;

    scta_dec_t  dec;
    logic       result_free;
    logic       stage_go;
    logic       poll_take;

    scta_decode u_decode (
        .word         (poll_word_reg),
        .shift_held   (shift_reg),
        .caps_lock_on (caps_reg),
        .dec          (dec)
    );

    // The result register can load when empty or being drained this cycle.
    assign result_free = !result_valid_reg || result.ready;

    // Advance the input stage unless it carries a character with nowhere to go.
    assign stage_go  = poll_valid_reg && (!dec.emit || result_free);
    assign poll_take = poll.valid && poll.ready;

    assign poll.ready = !poll_valid_reg || stage_go;

    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (stage_go)
        begin
            shift_next = dec.shift_held;
            caps_next  = dec.caps_lock_on;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (stage_go && dec.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg   <= 1'b0;
            shift_reg        <= 1'b0;
            caps_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.ready)
            begin
                poll_valid_reg <= poll.valid;
            end
            shift_reg        <= shift_next;
            caps_reg         <= caps_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: hold until a new word or character is loaded.
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            poll_word_reg <= poll.payload;
        end
        if (stage_go && dec.emit)
        begin
            result_char_reg <= dec.ascii_char;
        end
    end

    assign result.valid              = result_valid_reg;
    assign result.payload.ascii_char = result_char_reg;

`ifndef SYNTHESIS
    // A shift make that leaves the input stage leaves shift held.
    a_shift_make_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && poll_word_reg.buffer_full && !poll_word_reg.from_aux
            && !poll_word_reg.scan_code[BREAK_BIT]
            && (poll_word_reg.scan_code[6:0] == KEY_LSHIFT
                || poll_word_reg.scan_code[6:0] == KEY_RSHIFT))
        |=> shift_reg)
        else $error("shift make did not set shift flag");

    // A caps lock make flips caps lock.
    a_caps_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && poll_word_reg.buffer_full && !poll_word_reg.from_aux
            && !poll_word_reg.scan_code[BREAK_BIT]
            && poll_word_reg.scan_code[6:0] == KEY_CAPSLOCK)
        |=> caps_reg != $past(caps_reg))
        else $error("caps lock make did not toggle");

    // Releases never touch caps lock.
    a_break_keeps_caps: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && poll_word_reg.scan_code[BREAK_BIT])
        |=> $stable(caps_reg))
        else $error("release changed caps lock");

    // An empty input stage always takes a word, even with the result stalled.
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !poll_valid_reg |-> poll.ready)
        else $error("input stage empty but not ready");
`endif

endmodule

// ----- hw/rtl/scta_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_decode
// Classify one poll word, update the modifier flags and look up the character.
// ----------------------------------------------------------------------------
module scta_decode
    import scta_pkg::*;
(
    input  poll_word_t word,
    input  logic       shift_held,
    input  logic       caps_lock_on,
    output scta_dec_t  dec
);

    logic [6:0] lo_char;
    logic [6:0] hi_char;
    logic       is_letter;
    logic       use_upper;
    logic       is_break;
    logic [6:0] key;

    assign is_break = word.scan_code[BREAK_BIT];
    assign key      = word.scan_code[6:0];
    assign lo_char  = plain_char(key[5:0]);
    assign hi_char  = shifted_char(key[5:0]);

    always_comb
    begin
        is_letter = lo_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
        use_upper = is_letter ? (shift_held ^ caps_lock_on) : shift_held;

        dec.emit         = 1'b0;
        dec.ascii_char   = use_upper ? hi_char : lo_char;
        dec.shift_held   = shift_held;
        dec.caps_lock_on = caps_lock_on;

        // Drop empty polls and mouse bytes.
        if (word.buffer_full && !word.from_aux)
        begin
            if (is_break)
            begin
                if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                begin
                    dec.shift_held = 1'b0;
                end
            end
            else if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            begin
                dec.shift_held = 1'b1;
            end
            else if (key == KEY_CAPSLOCK)
            begin
                dec.caps_lock_on = !caps_lock_on;
            end
            else if (!key[6] && lo_char != CHAR_NONE)
            begin
                dec.emit = 1'b1;
            end
        end
    end

endmodule
